// File: rtl/dda_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dda_pkg
// Shared types for the DDA line rasterizer: controller states, function codes
// and the command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package dda_pkg;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_STEP = 1'b1;

  typedef enum logic [0:0] {
    S_IDLE,
    S_DIV
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic div_iter;
  } cmd_t;

  typedef struct packed {
    logic out_valid;
    logic busy;
    logic steps_zero;
    logic div_last;
  } status_t;

endpackage

// File: rtl/dda_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dda_in_if
// Input channel of the DDA line rasterizer: load or step items.
// ----------------------------------------------------------------------------
interface dda_in_if #(
  parameter int COORD_BITS = 10
);
  logic                  valid;
  logic                  ready;
  logic                  func;
  logic [COORD_BITS-1:0] x_start;
  logic [COORD_BITS-1:0] y_start;
  logic [COORD_BITS-1:0] x_end;
  logic [COORD_BITS-1:0] y_end;

  modport source (output valid, func, x_start, y_start, x_end, y_end, input ready);
  modport sink (input valid, func, x_start, y_start, x_end, y_end, output ready);
endinterface

// File: rtl/dda_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dda_out_if
// Output channel of the DDA line rasterizer: one pixel per item.
// ----------------------------------------------------------------------------
interface dda_out_if #(
  parameter int COORD_BITS = 10
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] pixel_x;
  logic [COORD_BITS-1:0] pixel_y;
  logic                  is_first;
  logic                  is_last;

  modport source (output valid, pixel_x, pixel_y, is_first, is_last, input ready);
  modport sink (input valid, pixel_x, pixel_y, is_first, is_last, output ready);
endinterface

// File: rtl/dda_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dda_ctrl
// Controller: input handshake, load/step decode and sequencing of the
// bit-serial increment division.
// ----------------------------------------------------------------------------
module dda_ctrl
  import dda_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  logic    in_func,
  input  logic    out_ready,
  output logic    in_ready,
  output cmd_t    cmd,
  input  status_t status
);

  state_t state;
  state_t state_next;
  logic   accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    in_ready     = 1'b0;
    accept       = 1'b0;
    cmd          = '0;
    case (state)
      S_IDLE: begin
        in_ready = !status.out_valid || out_ready;
        accept   = in_valid && in_ready;
        cmd.load = accept && (in_func == FUNC_LOAD);
        cmd.step = accept && (in_func == FUNC_STEP) && status.busy;
        if (cmd.load && !status.steps_zero) begin
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_iter = 1'b1;
        if (status.div_last) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/dda_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dda_dp
// Datapath: step count, two restoring dividers sharing one divisor and
// counter, fixed-point position accumulators and the output register.
// ----------------------------------------------------------------------------
module dda_dp
  import dda_pkg::*;
#(
  parameter int COORD_BITS = 10,
  parameter int FRAC_BITS  = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cmd_t                  cmd,
  output status_t               status,
  input  logic [COORD_BITS-1:0] x_start,
  input  logic [COORD_BITS-1:0] y_start,
  input  logic [COORD_BITS-1:0] x_end,
  input  logic [COORD_BITS-1:0] y_end,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic [COORD_BITS-1:0] pixel_x,
  output logic [COORD_BITS-1:0] pixel_y,
  output logic                  is_first,
  output logic                  is_last
);

  localparam int C     = COORD_BITS;
  localparam int F     = FRAC_BITS;
  localparam int W     = C + F;
  localparam int PW    = C + F + 1;
  localparam int CNT_W = $clog2(W);

  logic [C:0]       dx, dy;
  logic [C-1:0]     adx, ady, steps_in;
  logic [PW-1:0]    pos_x, pos_y;
  logic [PW-1:0]    pos_x_next, pos_y_next;
  logic [PW-1:0]    mag_x, mag_y;
  logic [C-1:0]     end_x, end_y;
  logic             neg_x, neg_y;
  logic [W-1:0]     qx, qy;
  logic [C-1:0]     rem_x, rem_y;
  logic [C:0]       trial_x, trial_y, diff_x, diff_y;
  logic             ge_x, ge_y;
  logic [C-1:0]     divisor;
  logic [CNT_W-1:0] cnt;
  logic [C-1:0]     steps_left, steps_dec;
  logic             busy;
  logic [C-1:0]     trunc_x, trunc_y;

  // step count from the load item
  assign dx       = {1'b0, x_end} - {1'b0, x_start};
  assign dy       = {1'b0, y_end} - {1'b0, y_start};
  assign adx      = dx[C] ? C'(-dx) : dx[C-1:0];
  assign ady      = dy[C] ? C'(-dy) : dy[C-1:0];
  assign steps_in = (adx > ady) ? adx : ady;

  // one quotient bit per cycle for each axis
  assign trial_x = {rem_x, qx[W-1]};
  assign trial_y = {rem_y, qy[W-1]};
  assign ge_x    = trial_x >= {1'b0, divisor};
  assign ge_y    = trial_y >= {1'b0, divisor};
  assign diff_x  = trial_x - {1'b0, divisor};
  assign diff_y  = trial_y - {1'b0, divisor};

  // quotient magnitude is at most one, so it fits F+1 bits
  assign mag_x      = {{(PW-F-1){1'b0}}, qx[F:0]};
  assign mag_y      = {{(PW-F-1){1'b0}}, qy[F:0]};
  assign pos_x_next = neg_x ? pos_x - mag_x : pos_x + mag_x;
  assign pos_y_next = neg_y ? pos_y - mag_y : pos_y + mag_y;
  assign trunc_x    = pos_x_next[PW-1] ? '0 : pos_x_next[W-1:F];
  assign trunc_y    = pos_y_next[PW-1] ? '0 : pos_y_next[W-1:F];
  assign steps_dec  = steps_left - 1'b1;

  assign status.out_valid  = out_valid;
  assign status.busy       = busy;
  assign status.steps_zero = (steps_in == '0);
  assign status.div_last   = (cnt == CNT_W'(W - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      out_valid  <= 1'b0;
      steps_left <= '0;
    end else begin
      if (cmd.load || cmd.step) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.load) begin
        busy       <= (steps_in != '0);
        steps_left <= steps_in;
      end else if (cmd.step) begin
        steps_left <= steps_dec;
        if (steps_dec == '0) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pos_x    <= {1'b0, x_start, {F{1'b0}}};
      pos_y    <= {1'b0, y_start, {F{1'b0}}};
      end_x    <= x_end;
      end_y    <= y_end;
      neg_x    <= dx[C];
      neg_y    <= dy[C];
      qx       <= {adx, {F{1'b0}}};
      qy       <= {ady, {F{1'b0}}};
      rem_x    <= '0;
      rem_y    <= '0;
      divisor  <= steps_in;
      cnt      <= '0;
      pixel_x  <= x_start;
      pixel_y  <= y_start;
      is_first <= 1'b1;
      is_last  <= (steps_in == '0);
    end else if (cmd.div_iter) begin
      qx    <= {qx[W-2:0], ge_x};
      qy    <= {qy[W-2:0], ge_y};
      rem_x <= ge_x ? diff_x[C-1:0] : trial_x[C-1:0];
      rem_y <= ge_y ? diff_y[C-1:0] : trial_y[C-1:0];
      cnt   <= cnt + 1'b1;
    end else if (cmd.step) begin
      is_first <= 1'b0;
      if (steps_dec == '0) begin
        pos_x   <= {1'b0, end_x, {F{1'b0}}};
        pos_y   <= {1'b0, end_y, {F{1'b0}}};
        pixel_x <= end_x;
        pixel_y <= end_y;
        is_last <= 1'b1;
      end else begin
        pos_x   <= pos_x_next;
        pos_y   <= pos_y_next;
        pixel_x <= trunc_x;
        pixel_y <= trunc_y;
        is_last <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/dda_line_rasterizer.sv
`timescale 1ns / 1ps
// Every item that gives a pixel shows it in the cycle after it is accepted.
// Step items: one per cycle while the output is drained.
// Load items: after a load with distinct endpoints the input stalls while the
//   bit-serial increment dividers run (one quotient bit a cycle).
// Reset: synchronous, active high; clears the controller, line-busy flag and output valid.
// ----------------------------------------------------------------------------
// dda_line_rasterizer
// DDA line generator top level: controller plus datapath on two channels.
// ----------------------------------------------------------------------------
module dda_line_rasterizer
  import dda_pkg::*;
#(
  parameter int COORD_BITS = 10,
  parameter int FRAC_BITS  = 16
) (
  input logic       clk,
  input logic       rst,
  dda_in_if.sink    in_ch,
  dda_out_if.source out_ch
);

  cmd_t    cmd;
  status_t status;

  dda_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_func   (in_ch.func),
    .out_ready (out_ch.ready),
    .in_ready  (in_ch.ready),
    .cmd       (cmd),
    .status    (status)
  );

  dda_dp #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .x_start   (in_ch.x_start),
    .y_start   (in_ch.y_start),
    .x_end     (in_ch.x_end),
    .y_end     (in_ch.y_end),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .pixel_x   (out_ch.pixel_x),
    .pixel_y   (out_ch.pixel_y),
    .is_first  (out_ch.is_first),
    .is_last   (out_ch.is_last)
  );

endmodule

// File: rtl/dda_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dda_chk
// Port-level checks for the DDA line rasterizer, bound to the top level.
// ----------------------------------------------------------------------------
module dda_chk
  import dda_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic in_func,
  input logic out_valid,
  input logic out_ready,
  input logic out_is_first
);

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("output item dropped while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  a_load_first: assert property (@(posedge clk) disable iff (rst)
    in_acc && (in_func == FUNC_LOAD) |=> out_valid && out_is_first)
    else $error("load item did not give a start pixel");

  a_step_not_first: assert property (@(posedge clk) disable iff (rst)
    in_acc && (in_func == FUNC_STEP) |=> !(out_valid && out_is_first))
    else $error("step item gave a start pixel");

endmodule

bind dda_line_rasterizer dda_chk u_chk (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .in_func      (in_ch.func),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_is_first (out_ch.is_first)
);
